[hw/rtl/tmas_pkg.sv]
// Shared widths and constants of the trajectory moving-average stabiliser.
package tmas_pkg;

  localparam int SHIFT_W  = 24;
  localparam int ANGLE_W  = 20;
  localparam int TRAJ_W   = 40;
  localparam int SUM_W    = 48;
  localparam int FIX_W    = TRAJ_W + 2;
  localparam int FRAME_W  = 16;
  localparam int RADIUS_W = 6;
  localparam int CNT_W    = 7;
  localparam int FILL_W   = 8;
  localparam int DIVC_W   = 6;
  localparam int LANES    = 3;

  localparam logic [RADIUS_W-1:0] RADIUS_AT_RESET = 6'd50;
  localparam logic [FILL_W-1:0]   FILL_CAP        = 8'd255;
  localparam logic [DIVC_W-1:0]   DIV_LAST_STEP   = 6'(SUM_W - 1);

  // Lane order of the three motion components.
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_A = 2;

endpackage

[hw/rtl/trajectory_moving_average_stabilizer_core.sv]
// Trajectory moving-average stabiliser: ring stores, window sequencer and divider.
//
// Motion requests (shift_x_i, shift_y_i, turn_angle_i, is_final_i) arrive on a
// valid/stall channel and are taken only while the sequencer is idle. Each
// request updates the saturating trajectory sums and writes them plus the raw
// motion into synchronous ring memories in the cycle the request is taken.
// Once R+1 frames are pending, a request yields one result for the frame R
// back; a request with is_final_i set yields every pending frame, oldest first,
// the last one marked with end_of_run_o, then the sequence restarts at frame 0.
// Each result reads the window (up to 2R+1 entries of the trajectory memory,
// one read port at one entry a cycle), adds half the window length to the
// magnitude for rounding, runs the bit-serial restoring divider (three lanes
// in parallel), then restores the sign and loads the output stage.
// Results sit in an output register; while the receiver stalls, the register
// holds and the sequencer waits before loading the next result, but an idle
// sequencer still takes new requests.
// The radius register resets to 50 and is latched at the first request of a
// sequence. Reset clears sums and counters; the ring memories are not cleared
// and are read only at entries written in the running sequence.
module trajectory_moving_average_stabilizer_core #(
  parameter int MAX_RADIUS = 63,
  parameter int PATH_DEPTH = 128
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [tmas_pkg::RADIUS_W-1:0]           cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [tmas_pkg::SHIFT_W-1:0]     shift_x_i,
  input  logic signed [tmas_pkg::SHIFT_W-1:0]     shift_y_i,
  input  logic signed [tmas_pkg::ANGLE_W-1:0]     turn_angle_i,
  input  logic                                    is_final_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [tmas_pkg::FRAME_W-1:0]            frame_number_o,
  output logic signed [tmas_pkg::SHIFT_W-1:0]     fixed_x_o,
  output logic signed [tmas_pkg::SHIFT_W-1:0]     fixed_y_o,
  output logic signed [tmas_pkg::ANGLE_W-1:0]     fixed_angle_o,
  output logic signed [tmas_pkg::TRAJ_W-1:0]      smooth_x_o,
  output logic signed [tmas_pkg::TRAJ_W-1:0]      smooth_y_o,
  output logic signed [tmas_pkg::TRAJ_W-1:0]      smooth_angle_o,
  output logic                                    end_of_run_o
);

  localparam int SW   = tmas_pkg::SHIFT_W;
  localparam int AW_  = tmas_pkg::ANGLE_W;
  localparam int TW   = tmas_pkg::TRAJ_W;
  localparam int SUMW = tmas_pkg::SUM_W;
  localparam int FXW  = tmas_pkg::FIX_W;
  localparam int RW   = tmas_pkg::RADIUS_W;
  localparam int CW   = tmas_pkg::CNT_W;
  localparam int FW   = tmas_pkg::FILL_W;
  localparam int NL   = tmas_pkg::LANES;

  localparam int RAW_DEPTH  = MAX_RADIUS + 1;
  localparam int PATH_AW    = $clog2(PATH_DEPTH);
  localparam int RAW_AW     = $clog2(RAW_DEPTH);
  localparam int HALF_DEPTH = (PATH_DEPTH - 1) / 2;
  localparam int RADIUS_LIM = (MAX_RADIUS < HALF_DEPTH) ? MAX_RADIUS : HALF_DEPTH;

  localparam logic [RW-1:0]      RADIUS_LIM_V = RW'(RADIUS_LIM);
  localparam logic [PATH_AW:0]   PATH_DEPTH_V = (PATH_AW + 1)'(PATH_DEPTH);
  localparam logic [PATH_AW-1:0] PATH_LAST    = PATH_AW'(PATH_DEPTH - 1);
  localparam logic [RAW_AW-1:0]  RAW_LAST     = RAW_AW'(RAW_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic signed [FXW-1:0] SHIFT_MAX = FXW'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [FXW-1:0] SHIFT_MIN = -SHIFT_MAX - FXW'(1);
  localparam logic signed [FXW-1:0] ANGLE_MAX = FXW'((64'sd1 <<< (AW_ - 1)) - 1);
  localparam logic signed [FXW-1:0] ANGLE_MIN = -ANGLE_MAX - FXW'(1);

  // Memories
  logic signed [TW-1:0]  path_mem_x [PATH_DEPTH];
  logic signed [TW-1:0]  path_mem_y [PATH_DEPTH];
  logic signed [TW-1:0]  path_mem_a [PATH_DEPTH];
  logic signed [SW-1:0]  raw_mem_x  [RAW_DEPTH];
  logic signed [SW-1:0]  raw_mem_y  [RAW_DEPTH];
  logic signed [AW_-1:0] raw_mem_a  [RAW_DEPTH];

  logic signed [TW-1:0]  path_rd_q [NL];
  logic signed [SW-1:0]  raw_rd_x_q, raw_rd_y_q;
  logic signed [AW_-1:0] raw_rd_a_q;

  // Control and datapath registers
  logic [2:0]               state_q;
  logic [RW-1:0]            radius_cfg_q, run_radius_q;
  logic signed [TW-1:0]     run_q [NL];
  logic [PATH_AW-1:0]       path_pos_q;
  logic [RAW_AW-1:0]        raw_pos_q;
  logic [tmas_pkg::FRAME_W-1:0] taken_q, given_q;
  logic [FW-1:0]            fill_q;
  logic                     flush_q;
  logic [RW-1:0]            age_q;
  logic [PATH_AW-1:0]       k_q, kend_q;
  logic                     issue_done_q, pv_q, pc_q;
  logic [CW-1:0]            cnt_q;
  logic signed [SUMW-1:0]   acc_q [NL];
  logic signed [TW-1:0]     center_q [NL];
  logic [SUMW-1:0]          dv_q [NL];
  logic [CW-1:0]            rem_q [NL];
  logic                     neg_q [NL];
  logic [tmas_pkg::DIVC_W-1:0] div_cnt_q;
  logic signed [TW-1:0]     smooth_q [NL];
  logic                     out_valid_q;

  // Accept and trajectory update
  logic                     in_acc;
  logic [RW-1:0]            r_use;
  logic signed [TW-1:0]     delta [NL];
  logic signed [TW-1:0]     run_d [NL];
  logic signed [TW:0]       run_sum [NL];
  logic [PATH_AW-1:0]       path_pos_d;
  logic [RAW_AW-1:0]        raw_pos_d;
  logic [tmas_pkg::FRAME_W-1:0] pend_diff;
  logic [CW-1:0]            r_plus;
  logic [CW-1:0]            pend;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    r_use = run_radius_q;
    if (fill_q == '0) begin
      r_use = (radius_cfg_q > RADIUS_LIM_V) ? RADIUS_LIM_V : radius_cfg_q;
    end
  end

  assign delta[tmas_pkg::LANE_X] = {{(TW - SW){shift_x_i[SW-1]}}, shift_x_i};
  assign delta[tmas_pkg::LANE_Y] = {{(TW - SW){shift_y_i[SW-1]}}, shift_y_i};
  assign delta[tmas_pkg::LANE_A] = {{(TW - AW_){turn_angle_i[AW_-1]}}, turn_angle_i};

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      run_sum[l] = {run_q[l][TW-1], run_q[l]} + {delta[l][TW-1], delta[l]};
      if (run_sum[l][TW] != run_sum[l][TW-1]) begin
        run_d[l] = run_sum[l][TW] ? {1'b1, {(TW - 1){1'b0}}} : {1'b0, {(TW - 1){1'b1}}};
      end else begin
        run_d[l] = run_sum[l][TW-1:0];
      end
    end
  end

  assign path_pos_d = (path_pos_q == PATH_LAST) ? '0 : path_pos_q + PATH_AW'(1);
  assign raw_pos_d  = (raw_pos_q == RAW_LAST) ? '0 : raw_pos_q + RAW_AW'(1);

  assign pend_diff = taken_q + tmas_pkg::FRAME_W'(1) - given_q;
  assign r_plus    = CW'(r_use) + CW'(1);
  assign pend      = (pend_diff > tmas_pkg::FRAME_W'(r_plus)) ? r_plus : pend_diff[CW-1:0];

  // Window bounds
  logic [FW-1:0]      room;
  logic [RW-1:0]      older;
  logic [PATH_AW:0]   addr_diff;
  logic [PATH_AW-1:0] path_addr;
  logic               issue;

  always_comb begin
    room  = (fill_q > FW'(age_q)) ? fill_q - FW'(1) - FW'(age_q) : '0;
    older = (room > FW'(run_radius_q)) ? run_radius_q : room[RW-1:0];
  end

  always_comb begin
    addr_diff = {1'b0, path_pos_q} - {1'b0, k_q};
    if (path_pos_q < k_q) begin
      addr_diff = addr_diff + PATH_DEPTH_V;
    end
    path_addr = addr_diff[PATH_AW-1:0];
  end

  assign issue = (state_q == S_READ) && !issue_done_q;

  logic [RAW_AW:0]   raw_diff;
  logic [RAW_AW-1:0] raw_addr;

  always_comb begin
    raw_diff = {1'b0, raw_pos_q} - (RAW_AW + 1)'(age_q);
    if ((RAW_AW + 1)'(raw_pos_q) < (RAW_AW + 1)'(age_q)) begin
      raw_diff = raw_diff + (RAW_AW + 1)'(RAW_DEPTH);
    end
    raw_addr = raw_diff[RAW_AW-1:0];
  end

  // Memory writes and reads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      path_mem_x[path_pos_d] <= run_d[tmas_pkg::LANE_X];
      path_mem_y[path_pos_d] <= run_d[tmas_pkg::LANE_Y];
      path_mem_a[path_pos_d] <= run_d[tmas_pkg::LANE_A];
      raw_mem_x[raw_pos_d]   <= shift_x_i;
      raw_mem_y[raw_pos_d]   <= shift_y_i;
      raw_mem_a[raw_pos_d]   <= turn_angle_i;
    end
    if (issue) begin
      path_rd_q[tmas_pkg::LANE_X] <= path_mem_x[path_addr];
      path_rd_q[tmas_pkg::LANE_Y] <= path_mem_y[path_addr];
      path_rd_q[tmas_pkg::LANE_A] <= path_mem_a[path_addr];
    end
    if (state_q == S_PREP) begin
      raw_rd_x_q <= raw_mem_x[raw_addr];
      raw_rd_y_q <= raw_mem_y[raw_addr];
      raw_rd_a_q <= raw_mem_a[raw_addr];
    end
  end

  // Divider step, one quotient bit a cycle in each lane
  logic [CW:0]     rem_sh [NL];
  logic            ge [NL];
  logic [SUMW-1:0] mag [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rem_sh[l] = {rem_q[l], dv_q[l][SUMW-1]};
      ge[l]     = rem_sh[l] >= {1'b0, cnt_q};
      mag[l]    = (acc_q[l][SUMW-1] ? -acc_q[l] : acc_q[l]) + SUMW'(cnt_q >> 1);
    end
  end

  // Corrected motion
  logic signed [FXW-1:0] fix_v [NL];
  logic signed [SW-1:0]  fix_x, fix_y;
  logic signed [AW_-1:0] fix_a;
  logic signed [FXW-1:0] raw_ext [NL];

  assign raw_ext[tmas_pkg::LANE_X] = {{(FXW - SW){raw_rd_x_q[SW-1]}}, raw_rd_x_q};
  assign raw_ext[tmas_pkg::LANE_Y] = {{(FXW - SW){raw_rd_y_q[SW-1]}}, raw_rd_y_q};
  assign raw_ext[tmas_pkg::LANE_A] = {{(FXW - AW_){raw_rd_a_q[AW_-1]}}, raw_rd_a_q};

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      fix_v[l] = raw_ext[l] + {{2{smooth_q[l][TW-1]}}, smooth_q[l]}
                 - {{2{center_q[l][TW-1]}}, center_q[l]};
    end
    fix_x = (fix_v[tmas_pkg::LANE_X] > SHIFT_MAX) ? SHIFT_MAX[SW-1:0] :
            (fix_v[tmas_pkg::LANE_X] < SHIFT_MIN) ? SHIFT_MIN[SW-1:0] :
            fix_v[tmas_pkg::LANE_X][SW-1:0];
    fix_y = (fix_v[tmas_pkg::LANE_Y] > SHIFT_MAX) ? SHIFT_MAX[SW-1:0] :
            (fix_v[tmas_pkg::LANE_Y] < SHIFT_MIN) ? SHIFT_MIN[SW-1:0] :
            fix_v[tmas_pkg::LANE_Y][SW-1:0];
    fix_a = (fix_v[tmas_pkg::LANE_A] > ANGLE_MAX) ? ANGLE_MAX[AW_-1:0] :
            (fix_v[tmas_pkg::LANE_A] < ANGLE_MIN) ? ANGLE_MIN[AW_-1:0] :
            fix_v[tmas_pkg::LANE_A][AW_-1:0];
  end

  logic out_free;
  logic load_out;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_OUT) && out_free;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      radius_cfg_q <= tmas_pkg::RADIUS_AT_RESET;
      run_radius_q <= (tmas_pkg::RADIUS_AT_RESET > RADIUS_LIM_V) ? RADIUS_LIM_V :
                      tmas_pkg::RADIUS_AT_RESET;
      path_pos_q   <= '0;
      raw_pos_q    <= '0;
      taken_q      <= '0;
      given_q      <= '0;
      fill_q       <= '0;
      flush_q      <= 1'b0;
      age_q        <= '0;
      k_q          <= '0;
      kend_q       <= '0;
      issue_done_q <= 1'b0;
      pv_q         <= 1'b0;
      pc_q         <= 1'b0;
      cnt_q        <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      for (int l = 0; l < NL; l++) begin
        run_q[l]    <= '0;
        acc_q[l]    <= '0;
        center_q[l] <= '0;
        dv_q[l]     <= '0;
        rem_q[l]    <= '0;
        neg_q[l]    <= 1'b0;
        smooth_q[l] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        radius_cfg_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            run_radius_q <= r_use;
            path_pos_q   <= path_pos_d;
            raw_pos_q    <= raw_pos_d;
            fill_q       <= (fill_q == tmas_pkg::FILL_CAP) ? fill_q : fill_q + FW'(1);
            if (is_final_i) begin
              // drop the sums now: the flush reads only the stores
              for (int l = 0; l < NL; l++) run_q[l] <= '0;
              taken_q <= '0;
              flush_q <= 1'b1;
              age_q   <= RW'(pend - CW'(1));
              state_q <= S_PREP;
            end else begin
              for (int l = 0; l < NL; l++) run_q[l] <= run_d[l];
              taken_q <= taken_q + tmas_pkg::FRAME_W'(1);
              flush_q <= 1'b0;
              if (pend == r_plus) begin
                age_q   <= r_use;
                state_q <= S_PREP;
              end
            end
          end
        end
        S_PREP: begin
          kend_q       <= PATH_AW'(CW'(age_q) + CW'(older));
          cnt_q        <= CW'(age_q) + CW'(older) + CW'(1);
          k_q          <= '0;
          issue_done_q <= 1'b0;
          pv_q         <= 1'b0;
          pc_q         <= 1'b0;
          for (int l = 0; l < NL; l++) acc_q[l] <= '0;
          state_q <= S_READ;
        end
        S_READ: begin
          pv_q <= issue;
          pc_q <= issue && (k_q == PATH_AW'(age_q));
          if (issue) begin
            if (k_q == kend_q) begin
              issue_done_q <= 1'b1;
            end else begin
              k_q <= k_q + PATH_AW'(1);
            end
          end
          if (pv_q) begin
            for (int l = 0; l < NL; l++) begin
              acc_q[l] <= acc_q[l] + {{(SUMW - TW){path_rd_q[l][TW-1]}}, path_rd_q[l]};
              if (pc_q) center_q[l] <= path_rd_q[l];
            end
          end
          if (issue_done_q && !pv_q) begin
            for (int l = 0; l < NL; l++) begin
              neg_q[l] <= acc_q[l][SUMW-1];
              dv_q[l]  <= mag[l];
              rem_q[l] <= '0;
            end
            div_cnt_q <= tmas_pkg::DIV_LAST_STEP;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          for (int l = 0; l < NL; l++) begin
            rem_q[l] <= ge[l] ? CW'(rem_sh[l] - {1'b0, cnt_q}) : rem_sh[l][CW-1:0];
            dv_q[l]  <= {dv_q[l][SUMW-2:0], ge[l]};
          end
          if (div_cnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            div_cnt_q <= div_cnt_q - tmas_pkg::DIVC_W'(1);
          end
        end
        S_FIN: begin
          for (int l = 0; l < NL; l++) begin
            smooth_q[l] <= neg_q[l] ? -dv_q[l][TW-1:0] : dv_q[l][TW-1:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (flush_q && (age_q != '0)) begin
              age_q   <= age_q - RW'(1);
              given_q <= given_q + tmas_pkg::FRAME_W'(1);
              state_q <= S_PREP;
            end else begin
              if (flush_q) begin
                given_q <= '0;
                fill_q  <= '0;
                flush_q <= 1'b0;
              end else begin
                given_q <= given_q + tmas_pkg::FRAME_W'(1);
              end
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      frame_number_o <= given_q;
      fixed_x_o      <= fix_x;
      fixed_y_o      <= fix_y;
      fixed_angle_o  <= fix_a;
      smooth_x_o     <= smooth_q[tmas_pkg::LANE_X];
      smooth_y_o     <= smooth_q[tmas_pkg::LANE_Y];
      smooth_angle_o <= smooth_q[tmas_pkg::LANE_A];
      end_of_run_o   <= flush_q && (age_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
